// File: rtl/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int COLOUR_W = 4;
  localparam int CFG_IDX_W = 1;

  // Modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

  // Sweep counter load codes
  localparam logic [1:0] SW_HOLD     = 2'd0;
  localparam logic [1:0] SW_ZERO     = 2'd1;
  localparam logic [1:0] SW_COLS     = 2'd2;
  localparam logic [1:0] SW_LAST_ROW = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  character;
    logic [INDEX_W-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [OCOL_W-1:0] cursor_column;
    logic [OROW_W-1:0] cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
  } out_t;

  typedef struct packed {
    logic       take;
    logic       exec_put;
    logic [1:0] sweep_init;
    logic       copy_step;
    logic       fill_step;
    logic       read_issue;
    logic       home;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              need_scroll;
    logic              sweep_last;
    logic              out_free;
  } status_t;

endpackage

// File: rtl/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.mode)
          MODE_PUT: begin
            cmd.exec_put = 1'b1;
            if (status.need_scroll) begin
              cmd.sweep_init = SW_COLS;
              state_next     = S_COPY;
            end else begin
              state_next = S_FINISH;
            end
          end
          MODE_CLEAR: begin
            cmd.home       = 1'b1;
            cmd.sweep_init = SW_ZERO;
            state_next     = S_CLEAR;
          end
          MODE_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = S_READ;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.sweep_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // last copied cell is written back this cycle
        cmd.sweep_init = SW_LAST_ROW;
        state_next     = S_BLANK;
      end
      S_BLANK, S_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (status.sweep_last) state_next = S_FINISH;
      end
      S_READ: state_next = S_FINISH;
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/tcw_dp.sv
module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_t                 out_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [COLOUR_W-1:0] fg;
  logic [COLOUR_W-1:0] bg;

  logic [MODE_W-1:0]  mode_q;
  logic [CHAR_W-1:0]  char_q;
  logic [INDEX_W-1:0] idx_q;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic          scrolled;

  logic [AW-1:0] sweep;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;

  logic [CELL_W-1:0] cell_char;
  logic [CELL_W-1:0] cell_blank;
  logic [AW-1:0]     base;
  logic [AW-1:0]     pos;
  logic [CW:0]       col_x;
  logic [CW:0]       col_tab;
  logic [CW:0]       col_n;
  logic              row_adv;
  logic [RW:0]       row_x;
  logic              need_scroll;
  logic              put_we;
  logic [AW-1:0]     put_addr;
  logic [CELL_W-1:0] put_data;

  logic              we;
  logic [AW-1:0]     wa;
  logic [CELL_W-1:0] wd;
  logic              re;
  logic [AW-1:0]     ra;

  logic [AW+INDEX_W-1:0] idx_wide;
  logic [AW+POS_W-1:0]   pos_wide;
  logic [CW+OCOL_W-1:0]  col_wide;
  logic [RW+OROW_W-1:0]  row_wide;
  logic                  idx_ok;

  assign cell_char  = {bg, fg, char_q};
  assign cell_blank = {bg, fg, CH_BLANK};

  assign base    = AW'(row) * AW'(COLUMNS);
  assign pos     = base + AW'(col);
  assign col_x   = {1'b0, col};
  assign col_tab = col_x + (CW+1)'(8);

  // cursor step for one character
  always_comb begin
    col_n    = col_x;
    row_adv  = 1'b0;
    put_we   = 1'b0;
    put_addr = pos;
    put_data = cell_char;
    case (char_q)
      CH_LF: begin
        col_n   = '0;
        row_adv = 1'b1;
      end
      CH_CR: col_n = '0;
      CH_TAB: col_n = {col_tab[CW:3], 3'b000};
      CH_BS: begin
        if (col != '0) begin
          col_n    = col_x - (CW+1)'(1);
          put_we   = 1'b1;
          put_addr = pos - AW'(1);
          put_data = cell_blank;
        end
      end
      default: begin
        put_we = 1'b1;
        col_n  = col_x + (CW+1)'(1);
      end
    endcase
    if (col_n >= (CW+1)'(COLUMNS)) begin
      col_n   = '0;
      row_adv = 1'b1;
    end
  end

  assign row_x       = {1'b0, row} + (RW+1)'(row_adv);
  assign need_scroll = (row_x >= (RW+1)'(ROWS));

  assign idx_wide = {{AW{1'b0}}, idx_q};
  assign idx_ok   = (idx_wide < (AW+INDEX_W)'(CELLS));

  // single write port: pending copy, put, fill
  always_comb begin
    we = 1'b0;
    wa = sweep;
    wd = cell_blank;
    if (pend) begin
      we = 1'b1;
      wa = pend_addr;
      wd = rd_data;
    end else if (cmd.exec_put && put_we) begin
      we = 1'b1;
      wa = put_addr;
      wd = put_data;
    end else if (cmd.fill_step) begin
      we = 1'b1;
    end
  end

  assign re = cmd.copy_step | cmd.read_issue;
  assign ra = cmd.copy_step ? sweep : idx_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    pend_addr <= sweep - AW'(COLUMNS);
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.sweep_init)
      SW_ZERO:     sweep <= '0;
      SW_COLS:     sweep <= AW'(COLUMNS);
      SW_LAST_ROW: sweep <= AW'(CELLS - COLUMNS);
      default: begin
        if (cmd.copy_step || cmd.fill_step) sweep <= sweep + AW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_q <= in_data.mode;
      char_q <= in_data.character;
      idx_q  <= in_data.cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FG:  fg <= cfg_data;
        REG_BG:  bg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      scrolled <= 1'b0;
    end else begin
      if (cmd.take) scrolled <= 1'b0;
      if (cmd.home) begin
        row <= '0;
        col <= '0;
      end else if (cmd.exec_put) begin
        col      <= col_n[CW-1:0];
        row      <= need_scroll ? RW'(ROWS - 1) : row_x[RW-1:0];
        scrolled <= need_scroll;
      end
    end
  end

  assign pos_wide = {{POS_W{1'b0}}, pos};
  assign col_wide = {{OCOL_W{1'b0}}, col};
  assign row_wide = {{OROW_W{1'b0}}, row};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.cursor_column   <= col_wide[OCOL_W-1:0];
      out_data.cursor_row      <= row_wide[OROW_W-1:0];
      out_data.cursor_position <= pos_wide[POS_W-1:0];
      out_data.scrolled        <= scrolled;
      out_data.cell_value      <= (mode_q == MODE_READ && idx_ok) ? rd_data : '0;
    end
  end

  assign status.mode        = mode_q;
  assign status.need_scroll = need_scroll;
  assign status.sweep_last  = (sweep == AW'(CELLS - 1));
  assign status.out_free    = !out_valid || !out_stall;

endmodule

// File: rtl/text_console_writer.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_stall    in_t  (mode, character, cell_index)
// out      out  out_valid/out_stall  out_t (cursor, scrolled, cell_value)
// cfg      in   cfg_we               cfg_index, cfg_data (colour registers)
//
// Each request is accepted, executed and its result loaded; a read adds a registered
// store read, and a clear blanks the store one cell a cycle (single-port store).
// A scroll copies the store up one line, pipelined one cell a cycle, then a drain step,
// then the bottom line blanked. Reset (rst, synchronous) homes the cursor and loads
// the colours; the store holds no reset state and is not cleared by reset.
// in_stall is high while a request is in work; a waiting result does not block the next accept.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer: one request at a time, sweeps for clear and scroll
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // cursor, colour registers, screen store and result register
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a taken request keeps the input stalled for at least the execute cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after request taken");

  // at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec_put, cmd.copy_step, cmd.fill_step, cmd.read_issue, cmd.finish}))
    else $error("conflicting datapath commands");

  // result register never overwritten while held
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  // a scroll only follows a row advance, which always homes the column
  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.scrolled) |-> (out_data.cursor_column == '0))
    else $error("scroll reported with non-zero column");

endmodule

// File: tb/text_console_writer_tb.sv
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS_DEF * ROWS_DEF;

  // Mode 3 has no meaning: the block must report the cursor and change nothing
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One line of the directed table: a request, how many times to send it, and,
  // where the answer is obvious, the result typed in by hand
  typedef struct packed {
    in_t        req;
    logic [3:0] reps;
    logic       typed;
    out_t       want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FG;
  logic [COLOUR_W-1:0]  cfg_data = '0;

  // Own copy of the console: screen, written flags, cursor and colours
  logic [CELL_W-1:0]   screen_q [CELLS];
  bit                  written_q [CELLS];
  int unsigned         row_q;
  int unsigned         col_q;
  logic [COLOUR_W-1:0] fg_q;
  logic [COLOUR_W-1:0] bg_q;

  out_t pending_q [$];   // results still owed by the block, oldest first
  int   errors = 0;
  bit   rx_gaps = 1'b1;  // receiver stalls allowed
  int   rx_left = 0;

  // Directed requests. After reset fg = 15, bg = 0, so a fresh attribute is 0x0F.
  dir_row_t dir_rows [16] = '{
    // read past the end of the screen, all index bits set
    '{'{MODE_READ,   8'h00,    11'd2047}, 4'd1,  1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 16'h0000}},
    // unused mode does nothing
    '{'{MODE_UNUSED, 8'hFF,    11'd0},    4'd1,  1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 16'h0000}},
    // top character code must not smear into the attribute
    '{'{MODE_PUT,    8'hFF,    11'd2047}, 4'd1,  1'b1, '{7'd1, 5'd0, 11'd1, 1'b0, 16'h0000}},
    '{'{MODE_READ,   8'h00,    11'd0},    4'd1,  1'b1, '{7'd1, 5'd0, 11'd1, 1'b0, 16'h0FFF}},
    '{'{MODE_PUT,    8'h00,    11'd0},    4'd1,  1'b0, '0},
    '{'{MODE_PUT,    CH_BS,    11'd0},    4'd1,  1'b0, '0},
    '{'{MODE_READ,   8'h00,    11'd1},    4'd1,  1'b0, '0},
    '{'{MODE_PUT,    CH_TAB,   11'd0},    4'd1,  1'b0, '0},
    '{'{MODE_PUT,    CH_CR,    11'd0},    4'd1,  1'b0, '0},
    // backspace at the left edge is a no-op
    '{'{MODE_PUT,    CH_BS,    11'd0},    4'd1,  1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 16'h0000}},
    '{'{MODE_PUT,    CH_LF,    11'd0},    4'd1,  1'b0, '0},
    '{'{MODE_CLEAR,  8'h00,    11'd0},    4'd1,  1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 16'h0000}},
    '{'{MODE_READ,   8'h00,    11'd1999}, 4'd1,  1'b1, '{7'd0, 5'd0, 11'd0, 1'b0, 16'h0F20}},
    // ten tabs run off the line end and wrap to the next row
    '{'{MODE_PUT,    CH_TAB,   11'd0},    4'd10, 1'b0, '0},
    '{'{MODE_PUT,    8'h41,    11'd0},    4'd1,  1'b0, '0},
    '{'{MODE_READ,   8'h00,    11'd80},   4'd1,  1'b0, '0}
  };

  // Colour plan per random phase; phases 3 and 4 take random colours
  logic [COLOUR_W-1:0] fg_plan [6] = '{4'd0, 4'd15, 4'd0,  4'd0, 4'd0, 4'd15};
  logic [COLOUR_W-1:0] bg_plan [6] = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0};

  text_console_writer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Write one cell with the attribute as it stands now
  function automatic void paint_cell(int unsigned idx, logic [CHAR_W-1:0] ch);
    screen_q[idx]  = {bg_q, fg_q, ch};
    written_q[idx] = 1'b1;
  endfunction

  // Step the console copy by one request and return the result it owes
  function automatic out_t advance_console(in_t r);
    out_t o;
    int unsigned k;
    o = '0;
    case (r.mode)
      MODE_PUT: begin
        if (r.character == CH_LF) begin
          col_q = 0;
          row_q++;
        end else if (r.character == CH_CR) begin
          col_q = 0;
        end else if (r.character == CH_TAB) begin
          col_q = (col_q + 8) & ~32'd7;
        end else if (r.character == CH_BS) begin
          if (col_q > 0) begin
            col_q--;
            paint_cell(row_q * COLUMNS_DEF + col_q, CH_BLANK);
          end
        end else begin
          paint_cell(row_q * COLUMNS_DEF + col_q, r.character);
          col_q++;
        end
        if (col_q >= COLUMNS_DEF) begin
          col_q = 0;
          row_q++;
        end
        // off the bottom: everything moves up a line, new bottom line blank
        if (row_q >= ROWS_DEF) begin
          for (k = 0; k < CELLS - COLUMNS_DEF; k++) begin
            screen_q[k]  = screen_q[k + COLUMNS_DEF];
            written_q[k] = written_q[k + COLUMNS_DEF];
          end
          for (k = CELLS - COLUMNS_DEF; k < CELLS; k++)
            paint_cell(k, CH_BLANK);
          row_q = ROWS_DEF - 1;
          o.scrolled = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (k = 0; k < CELLS; k++)
          paint_cell(k, CH_BLANK);
        row_q = 0;
        col_q = 0;
      end
      MODE_READ: begin
        if (r.cell_index < CELLS)
          o.cell_value = screen_q[r.cell_index];
      end
      default: ;
    endcase
    o.cursor_column   = OCOL_W'(col_q);
    o.cursor_row      = OROW_W'(row_q);
    o.cursor_position = POS_W'(row_q * COLUMNS_DEF + col_q);
    return o;
  endfunction

  // Mostly text with line breaks so the cursor reaches the bottom and scrolls;
  // some reads, rare clears and the odd unused mode
  function automatic in_t random_request();
    in_t r;
    int unsigned pick;
    r.mode       = MODE_PUT;
    r.character  = CHAR_W'($urandom_range(0, 255));
    r.cell_index = INDEX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 999);
    if (pick < 2) begin
      r.mode = MODE_CLEAR;
    end else if (pick < 22) begin
      r.mode = MODE_UNUSED;
    end else if (pick < 180) begin
      r.mode = MODE_READ;
      // never read a cell that holds nothing yet; go off the end instead
      if (r.cell_index < CELLS && !written_q[r.cell_index])
        r.cell_index = INDEX_W'(CELLS + $urandom_range(0, 2047 - CELLS));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        r.character = CH_LF;
      else if (pick < 14)
        r.character = CH_CR;
      else if (pick < 22)
        r.character = CH_TAB;
      else if (pick < 28)
        r.character = CH_BS;
    end
    return r;
  endfunction

  // Hold the request until taken, then log what it should produce
  task automatic offer_request(in_t r, bit gaps, bit typed, out_t want);
    out_t got;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    got = advance_console(r);
    pending_q.push_back(typed ? want : got);
  endtask

  // Let every owed result arrive and the block go quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0 || in_stall)
      @(posedge clk);
  endtask

  task automatic set_colours(logic [COLOUR_W-1:0] fg, logic [COLOUR_W-1:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= REG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fg_q = fg;
    bg_q = bg;
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, what, want, got);
    end
  endtask

  // Receiver: stall in bursts, with quiet stretches between;
  // never stalls once gaps are switched off
  always @(posedge clk) begin
    if (!rx_gaps) begin
      out_stall <= 1'b0;
      rx_left   <= 0;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_left   <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
      rx_left   <= $urandom_range(0, 20);
    end
  end

  // Result checker: each accepted result against the oldest owed one
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got 'h%0h", $time, out_data);
      end else begin
        want = pending_q.pop_front();
        check_field("cursor_column",   32'(want.cursor_column),
                    32'(out_data.cursor_column));
        check_field("cursor_row",      32'(want.cursor_row),
                    32'(out_data.cursor_row));
        check_field("cursor_position", 32'(want.cursor_position),
                    32'(out_data.cursor_position));
        check_field("scrolled",        32'(want.scrolled),
                    32'(out_data.scrolled));
        check_field("cell_value",      32'(want.cell_value),
                    32'(out_data.cell_value));
      end
    end
  end

  initial begin
    int ph;
    int n;
    int i;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    bit gaps;

    // console copy after reset: cursor home, reset colours, nothing written
    row_q = 0;
    col_q = 0;
    fg_q  = FG_RESET;
    bg_q  = BG_RESET;
    for (i = 0; i < CELLS; i++) begin
      screen_q[i]  = '0;
      written_q[i] = 1'b0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at reset colours
    for (i = 0; i < $size(dir_rows); i++)
      repeat (dir_rows[i].reps)
        offer_request(dir_rows[i].req, 1'b1, dir_rows[i].typed, dir_rows[i].want);

    // Random phases; between phases the sender holds off until all results are
    // in, then the colours change. The last phase runs flat out on both sides.
    for (ph = 0; ph < 6; ph++) begin
      fg = fg_plan[ph];
      bg = bg_plan[ph];
      if (ph == 3 || ph == 4) begin
        fg = COLOUR_W'($urandom_range(0, 15));
        bg = COLOUR_W'($urandom_range(0, 15));
      end
      gaps = (ph != 5);
      wait_drained();
      set_colours(fg, bg);
      rx_gaps = gaps;
      for (n = 0; n < 240; n++)
        offer_request(random_request(), gaps, 1'b0, '0);
    end

    wait_drained();
    // keep clocking to catch any stray result
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("** text_console_writer: PASSED **");
    else
      $display("** text_console_writer: FAILED **");
    $finish;
  end

  // Watchdog: far beyond a run where every request scrolls and every stall is long
  initial begin
    #120_000_000;
    $display("** text_console_writer: FAILED **");
    $finish;
  end

endmodule
